// ----- hw/rtl/rvod_pkg.sv -----
// Shared types, constants and lookup tables for the relay and valve output driver.
// Used by every module of the block; depends on nothing.
package rvod_pkg;

  localparam int RELAY_COUNT = 16;
  localparam int PHASE_STEPS = 8;
  localparam int PH_W        = $clog2(PHASE_STEPS);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [2:0] OP_SET_RELAY  = 3'd0;
  localparam logic [2:0] OP_STEP_VALVE = 3'd1;
  localparam logic [2:0] OP_RELEASE    = 3'd2;
  localparam logic [2:0] OP_BULK       = 3'd3;
  localparam logic [2:0] OP_REFRESH    = 3'd4;

  localparam logic [15:0] VALVE_A_BITS = 16'h1e00;
  localparam logic [15:0] VALVE_B_BITS = 16'hf000;
  localparam logic [15:0] VALVE_B_KEEP = 16'h0007;

  typedef struct packed {
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        shift;
    logic        pb;
  } job_t;

  function automatic logic [3:0] relay_bit(input logic [3:0] idx);
    logic [3:0] b;
    case (idx)
      4'd0:    b = 4'd15;
      4'd1:    b = 4'd6;
      4'd2:    b = 4'd7;
      4'd3:    b = 4'd3;
      4'd4:    b = 4'd5;
      4'd5:    b = 4'd4;
      4'd6:    b = 4'd2;
      4'd7:    b = 4'd1;
      4'd8:    b = 4'd0;
      4'd9:    b = 4'd9;
      4'd10:   b = 4'd10;
      4'd11:   b = 4'd11;
      4'd12:   b = 4'd12;
      4'd13:   b = 4'd13;
      4'd14:   b = 4'd14;
      default: b = 4'd15;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] phase_a(input logic [PH_W-1:0] idx);
    logic [15:0] p;
    case (idx)
      3'd0:    p = 16'h1000;
      3'd1:    p = 16'h1800;
      3'd2:    p = 16'h0800;
      3'd3:    p = 16'h0c00;
      3'd4:    p = 16'h0400;
      3'd5:    p = 16'h0600;
      3'd6:    p = 16'h0200;
      default: p = 16'h1200;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] phase_b(input logic [PH_W-1:0] idx);
    logic [15:0] p;
    case (idx)
      3'd0:    p = 16'h8000;
      3'd1:    p = 16'hc000;
      3'd2:    p = 16'h4000;
      3'd3:    p = 16'h6000;
      3'd4:    p = 16'h2000;
      3'd5:    p = 16'h3000;
      3'd6:    p = 16'h1000;
      default: p = 16'h9000;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/rvod_front.sv -----
// Command front end: accepts commands, updates the output words and phase indexes,
// and queues one output job per command. Depends on rvod_pkg.
module rvod_front import rvod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,
  input  logic [23:0] in_tdata,
  output logic        push_valid,
  input  logic        push_ready,
  output job_t        push_data
);

  logic [15:0]     word_a_r, word_a_nxt;
  logic [15:0]     word_b_r, word_b_nxt;
  logic [15:0]     last_a_r, last_a_nxt;
  logic [15:0]     last_b_r, last_b_nxt;
  logic [PH_W-1:0] ph_a_r, ph_a_nxt;
  logic [PH_W-1:0] ph_b_r, ph_b_nxt;

  logic [2:0]      op;
  logic [3:0]      relay_index;
  logic            relay_on;
  logic            valve_select;
  logic            direction;
  logic [15:0]     relay_word;
  logic [15:0]     mask;
  logic [PH_W-1:0] ph_cur;
  logic [PH_W-1:0] ph_step;
  logic            accept;

  assign op           = in_tuser;
  assign relay_index  = in_tdata[3:0];
  assign relay_on     = in_tdata[4];
  assign valve_select = in_tdata[5];
  assign direction    = in_tdata[6];
  assign relay_word   = in_tdata[22:7];

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  assign mask    = 16'd1 << relay_bit(relay_index);
  assign ph_cur  = valve_select ? ph_b_r : ph_a_r;
  assign ph_step = direction ? ph_cur - PH_W'(1) : ph_cur + PH_W'(1);

  always_comb begin
    word_a_nxt       = word_a_r;
    word_b_nxt       = word_b_r;
    last_a_nxt       = last_a_r;
    last_b_nxt       = last_b_r;
    ph_a_nxt         = ph_a_r;
    ph_b_nxt         = ph_b_r;
    push_data.shift  = 1'b0;
    push_data.pb     = 1'b0;
    case (op)
      OP_SET_RELAY: begin
        if ({1'b0, relay_index} < 5'(RELAY_COUNT)) begin
          word_a_nxt = relay_on ? (word_a_r | mask) : (word_a_r & ~mask);
        end
      end
      OP_STEP_VALVE: begin
        if (valve_select) begin
          word_b_nxt = (word_b_r & VALVE_B_KEEP) | phase_b(ph_b_r);
          ph_b_nxt   = ph_step;
        end else begin
          word_a_nxt = (word_a_r & ~VALVE_A_BITS) | phase_a(ph_a_r);
          ph_a_nxt   = ph_step;
        end
      end
      OP_RELEASE: begin
        if (valve_select) begin
          word_b_nxt = word_b_r & ~VALVE_B_BITS;
        end else begin
          word_a_nxt = word_a_r & ~VALVE_A_BITS;
        end
      end
      OP_BULK: begin
        word_a_nxt = (word_a_r & VALVE_A_BITS) | (relay_word & ~VALVE_A_BITS);
      end
      OP_REFRESH: begin
        push_data.shift = word_a_r != last_a_r;
        push_data.pb    = word_b_r != last_b_r;
        last_a_nxt      = word_a_r;
        last_b_nxt      = word_b_r;
      end
      default: begin
      end
    endcase
    push_data.word_a = word_a_nxt;
    push_data.word_b = word_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_a_r <= '0;
      word_b_r <= '0;
      last_a_r <= '0;
      last_b_r <= '0;
      ph_a_r   <= '0;
      ph_b_r   <= '0;
    end else if (accept) begin
      word_a_r <= word_a_nxt;
      word_b_r <= word_b_nxt;
      last_a_r <= last_a_nxt;
      last_b_r <= last_b_nxt;
      ph_a_r   <= ph_a_nxt;
      ph_b_r   <= ph_b_nxt;
    end
  end

endmodule

// ----- hw/rtl/rvod_queue.sv -----
// Short register queue of output jobs between the command front end and the
// serializer. Depends on rvod_pkg.
module rvod_queue import rvod_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  assign push_ready = count_r != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/rvod_back.sv -----
// Output serializer: turns each queued job into one result or sixteen shifted bits,
// MSB first, with the latch strobe on the last. Depends on rvod_pkg.
module rvod_back import rvod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  job_t        pop_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  job_t       job_r;
  logic       valid_r;
  logic [3:0] cnt_r;
  logic       done;
  logic       out_take;
  logic       serial_bit;

  assign done       = !job_r.shift || (cnt_r == 4'd15);
  assign out_take   = valid_r && out_tready;
  assign pop_ready  = !valid_r || (out_tready && done);
  assign serial_bit = job_r.shift && job_r.word_a[~cnt_r];

  assign out_tvalid = valid_r;
  assign out_tlast  = done;
  assign out_tdata  = {5'd0, job_r.pb, job_r.shift, serial_bit, job_r.word_b, job_r.word_a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (pop_valid && pop_ready) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (out_take && done) begin
      valid_r <= 1'b0;
    end else if (out_take) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job_r <= pop_data;
    end
  end

  a_cnt_only_when_shifting: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && cnt_r != 4'd0) |-> job_r.shift)
    else $error("bit counter advanced on a job that does not shift");

  a_cnt_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !done) |=> (valid_r && cnt_r == $past(cnt_r) + 4'd1))
    else $error("shift did not advance to the next bit");

  a_job_held_while_shifting: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !done) |=> $stable(job_r))
    else $error("job replaced before its last bit was sent");

endmodule

// ----- hw/rtl/relay_and_valve_output_driver_core.sv -----
// Relay and valve output driver: command front end, job queue and output serializer.
// Path: each accepted command's job is written into the job queue, then loaded into the serializer's job register.
// Throughput: one command per cycle while the four-entry job queue has room; a refresh
// that shifts word A holds the serializer for sixteen results, all other commands for one.
// Reset: synchronous, active low; both words, phase indexes and sent copies go to zero.
// Depends on rvod_pkg, rvod_front, rvod_queue and rvod_back.
module relay_and_valve_output_driver_core import rvod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[2:0]
  input  logic [2:0]  in_tuser,
  // relay_index[3:0], relay_on[4], valve_select[5], direction[6], relay_word[22:7]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // word_a[15:0], word_b[31:16], serial_bit[32], serial_valid[33], port_b_update[34]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  logic push_valid, push_ready;
  job_t push_data;
  logic pop_valid, pop_ready;
  job_t pop_data;

  rvod_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rvod_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rvod_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- test/rvod_output_checker.sv -----
// Output checker for the relay and valve output driver: watches both stream channels,
// predicts the result transfers of every accepted command and compares them in order.
// Depends on rvod_pkg for the op codes and the valve bit masks.
module rvod_output_checker import rvod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [2:0]  in_tuser,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        serial_bit;
    logic        serial_valid;
    logic        last;
    logic        port_b_update;
  } drive_frame_t;

  localparam logic [7:0][15:0] VALVE_A_PHASE = {
    16'h1200, 16'h0200, 16'h0600, 16'h0400, 16'h0c00, 16'h0800, 16'h1800, 16'h1000
  };
  localparam logic [7:0][15:0] VALVE_B_PHASE = {
    16'h9000, 16'h1000, 16'h3000, 16'h2000, 16'h6000, 16'h4000, 16'hc000, 16'h8000
  };
  localparam logic [15:0][3:0] RELAY_POS = {
    4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd0,
    4'd1, 4'd2, 4'd4, 4'd5, 4'd3, 4'd7, 4'd6, 4'd15
  };

  logic [15:0]      relay_word_q;
  logic [15:0]      valve_b_q;
  logic [15:0]      sent_a_q;
  logic [15:0]      sent_b_q;
  logic [1:0][2:0]  phase_q;
  drive_frame_t     frames_due[$];
  int               errs = 0;

  assign mismatch_count = errs;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errs++;
  endtask

  task automatic apply_command(input logic [2:0] op, input logic [23:0] d);
    logic [3:0]   idx;
    logic         on;
    logic         vsel;
    logic         dir;
    logic [15:0]  bulk;
    logic [15:0]  mask;
    drive_frame_t f;
    idx  = d[3:0];
    on   = d[4];
    vsel = d[5];
    dir  = d[6];
    bulk = d[22:7];
    f    = '0;
    case (op)
      OP_SET_RELAY: begin
        mask = 16'h0001 << RELAY_POS[idx];
        relay_word_q = on ? (relay_word_q | mask) : (relay_word_q & ~mask);
      end
      OP_STEP_VALVE: begin
        if (!vsel) begin
          relay_word_q = (relay_word_q & ~VALVE_A_BITS) | VALVE_A_PHASE[phase_q[0]];
        end else begin
          valve_b_q = (valve_b_q & VALVE_B_KEEP) | VALVE_B_PHASE[phase_q[1]];
        end
        phase_q[vsel] = dir ? phase_q[vsel] - 3'd1 : phase_q[vsel] + 3'd1;
      end
      OP_RELEASE: begin
        if (!vsel) begin
          relay_word_q = relay_word_q & ~VALVE_A_BITS;
        end else begin
          valve_b_q = valve_b_q & ~VALVE_B_BITS;
        end
      end
      OP_BULK: begin
        relay_word_q = (relay_word_q & VALVE_A_BITS) | (bulk & ~VALVE_A_BITS);
      end
      OP_REFRESH: begin
        f.word_a = relay_word_q;
        f.word_b = valve_b_q;
        f.port_b_update = (valve_b_q != sent_b_q);
        sent_b_q = valve_b_q;
        if (relay_word_q != sent_a_q) begin
          sent_a_q = relay_word_q;
          for (int i = 15; i >= 0; i--) begin
            f.serial_bit   = relay_word_q[i];
            f.serial_valid = 1'b1;
            f.last         = (i == 0);
            frames_due.push_back(f);
          end
        end else begin
          f.last = 1'b1;
          frames_due.push_back(f);
        end
        return;
      end
      default: begin
      end
    endcase
    f.word_a = relay_word_q;
    f.word_b = valve_b_q;
    f.last   = 1'b1;
    frames_due.push_back(f);
  endtask

  always @(posedge clk) begin : watch_channels
    drive_frame_t got;
    drive_frame_t want;
    if (!rst_n) begin
      relay_word_q = '0;
      valve_b_q    = '0;
      sent_a_q     = '0;
      sent_b_q     = '0;
      phase_q      = '0;
      frames_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.word_a        = out_tdata[15:0];
        got.word_b        = out_tdata[31:16];
        got.serial_bit    = out_tdata[32];
        got.serial_valid  = out_tdata[33];
        got.port_b_update = out_tdata[34];
        got.last          = out_tlast;
        if (frames_due.size() == 0) begin
          flag_mismatch("transfer with nothing due, word_a", got.word_a, 16'h0);
        end else begin
          want = frames_due.pop_front();
          if (got.word_a != want.word_a) flag_mismatch("word_a", got.word_a, want.word_a);
          if (got.word_b != want.word_b) flag_mismatch("word_b", got.word_b, want.word_b);
          if (got.serial_bit != want.serial_bit) begin
            flag_mismatch("serial_bit", 16'(got.serial_bit), 16'(want.serial_bit));
          end
          if (got.serial_valid != want.serial_valid) begin
            flag_mismatch("serial_valid", 16'(got.serial_valid), 16'(want.serial_valid));
          end
          if (got.last != want.last) begin
            flag_mismatch("last", 16'(got.last), 16'(want.last));
          end
          if (got.port_b_update != want.port_b_update) begin
            flag_mismatch("port_b_update", 16'(got.port_b_update),
                          16'(want.port_b_update));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata);
      end
    end
    results_pending <= frames_due.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the relay and valve output driver testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict.
// Depends on rvod_pkg, relay_and_valve_output_driver_core and rvod_output_checker.
module tb_top import rvod_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  relay_index;
    logic        relay_on;
    logic        valve_select;
    logic        direction;
    logic [15:0] relay_word;
  } cmd_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        hold_req;
  logic        hold_done = 1'b0;
  int          mismatch_count;
  int          results_pending;
  int          burst_left = 1;
  int          gap_max = 0;
  int          idle_run = 0;

  relay_and_valve_output_driver_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  rvod_output_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cmd_t cmd(input logic [2:0] op, input logic [3:0] idx, input logic on,
                               input logic vsel, input logic dir, input logic [15:0] word);
    cmd_t c;
    c.op           = op;
    c.relay_index  = idx;
    c.relay_on     = on;
    c.valve_select = vsel;
    c.direction    = dir;
    c.relay_word   = word;
    return c;
  endfunction

  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned roll;
    c = cmd(OP_REFRESH, 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
            16'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      c.op = OP_SET_RELAY;
    end else if (roll < 55) begin
      c.op = OP_STEP_VALVE;
    end else if (roll < 62) begin
      c.op = OP_RELEASE;
    end else if (roll < 72) begin
      c.op = OP_BULK;
    end else if (roll < 95) begin
      c.op = OP_REFRESH;
    end else begin
      case ($urandom_range(0, 2))
        0:       c.op = OP_SPARE_5;
        1:       c.op = OP_SPARE_6;
        default: c.op = OP_SPARE_7;
      endcase
    end
    return c;
  endfunction

  task automatic offer(input cmd_t c);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {1'b0, c.relay_word, c.direction, c.valve_select, c.relay_on,
                  c.relay_index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin : command_source
    cmd_t c;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    hold_req  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_max = 3;
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_SET_RELAY,  4'd0,  1'b1, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_SET_RELAY,  4'd15, 1'b1, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_SET_RELAY,  4'd8,  1'b1, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_SET_RELAY,  4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_BULK,       4'd0,  1'b0, 1'b0, 1'b0, 16'hffff));
    offer(cmd(OP_BULK,       4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_STEP_VALVE, 4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_STEP_VALVE, 4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    repeat (3) offer(cmd(OP_STEP_VALVE, 4'd0, 1'b0, 1'b0, 1'b1, 16'h0000));
    offer(cmd(OP_STEP_VALVE, 4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_STEP_VALVE, 4'd0,  1'b0, 1'b1, 1'b1, 16'h0000));
    offer(cmd(OP_STEP_VALVE, 4'd0,  1'b0, 1'b1, 1'b0, 16'h0000));
    offer(cmd(OP_BULK,       4'd0,  1'b0, 1'b0, 1'b0, 16'hffff));
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_RELEASE,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_RELEASE,    4'd0,  1'b0, 1'b1, 1'b0, 16'h0000));
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));
    offer(cmd(OP_SPARE_5,    4'd15, 1'b1, 1'b1, 1'b1, 16'hffff));
    offer(cmd(OP_SPARE_6,    4'd7,  1'b1, 1'b0, 1'b1, 16'h5a5a));
    offer(cmd(OP_SPARE_7,    4'd8,  1'b0, 1'b1, 1'b0, 16'ha5a5));
    offer(cmd(OP_REFRESH,    4'd0,  1'b0, 1'b0, 1'b0, 16'h0000));

    gap_max = 6;
    repeat (20) offer(random_command());

    gap_max = 0;
    hold_req <= 1'b1;
    for (int k = 0; k < 20; k++) begin
      c = random_command();
      c.op = k[0] ? OP_REFRESH : OP_BULK;
      offer(c);
    end
    in_tvalid <= 1'b0;
    drain_results();

    gap_max = 6;
    repeat (30) offer(random_command());
    gap_max = 0;
    repeat (30) offer(random_command());

    in_tvalid <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned tick;
    out_tready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        SINK_OPEN:   out_tready <= 1'b1;
        SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:     out_tready <= tick[2];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/rvod_pkg.sv
hw/rtl/rvod_front.sv
hw/rtl/rvod_queue.sv
hw/rtl/rvod_back.sv
hw/rtl/relay_and_valve_output_driver_core.sv
test/rvod_output_checker.sv
test/tb_top.sv
